// ----- design/kde_pkg.sv -----
// Package for the keyed decimal extractor: payload structs, register and
// status codes, and the digit collector step shared by the key prep and scan.
// No dependencies.
package kde_pkg;

    localparam int KEY_MAX_BYTES = 32;
    localparam logic [5:0] KEY_MAX = 6'd32;
    localparam logic [4:0] MAX_DIGITS = 5'd19;
    localparam logic [62:0] VALUE_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_LEN = 3'd0;
    localparam logic [2:0] CFG_KEY_W0 = 3'd1;
    localparam logic [2:0] CFG_KEY_W1 = 3'd2;
    localparam logic [2:0] CFG_KEY_W2 = 3'd3;
    localparam logic [2:0] CFG_KEY_W3 = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_TOO_MANY = 2'd2;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] number;
    } t_out_item;

    typedef logic [3:0][63:0] t_key_words;

    // State of the digit collector.
    typedef struct packed {
        logic [4:0]  count;
        logic        finished;
        logic        overflow;
        logic        sat;
        logic [62:0] acc;
    } t_coll;

    // What the key prep hands to the scan stage.
    typedef struct packed {
        logic [31:0][7:0] akey;
        logic [31:0]      amask;
        logic [5:0]       eff_len;
        t_coll            digest;
    } t_key_info;

    localparam t_coll COLL_CLEAR = '{count: 5'd0, finished: 1'b0, overflow: 1'b0,
                                     sat: 1'b0, acc: 63'd0};

    function automatic logic [7:0] key_byte(input t_key_words words, input logic [4:0] k);
        key_byte = words[k[4:3]][{k[2:0], 3'b000} +: 8];
    endfunction

    // One byte through the digit collector.
    function automatic t_coll feed_digit(input t_coll s, input logic [7:0] b);
        t_coll       r;
        logic [3:0]  d;
        logic [66:0] p;
        r = s;
        d = 4'(b - CH_ZERO);
        p = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1) + {63'b0, d};
        if (!(s.finished || s.overflow)) begin
            if (b >= CH_ZERO && b <= CH_NINE) begin
                if (s.count >= MAX_DIGITS) begin
                    r.overflow = 1'b1;
                end else begin
                    r.count = s.count + 5'd1;
                    if (s.sat || p > {4'b0, VALUE_MAX}) begin
                        r.sat = 1'b1;
                        r.acc = VALUE_MAX;
                    end else begin
                        r.acc = p[62:0];
                    end
                end
            end else if (s.count != 5'd0) begin
                r.finished = 1'b1;
            end
        end
        feed_digit = r;
    endfunction

endpackage

// ----- design/keyed_decimal_extractor.sv -----
// Keyed decimal extractor: finds a configured key in a byte stream and parses
// the first decimal run from the start of the match.
// Depends on kde_pkg, kde_key_prep, kde_scan and kde_out_buf.
//
// Usage: bytes of a string enter on the input channel (valid/stall), the last
// byte flagged by end_of_text. One transaction per string leaves on the output
// channel when its last byte is taken: status ok with the value, key not found,
// or too many digits (both with number -1). Other bytes produce nothing.
// The key is written through the configuration port between strings.
// Throughput: one byte per cycle unless the input stalls. A result is valid
// the cycle after its last byte is accepted if the result register is free or
// being read, else it waits in the skid entry. After a configuration write,
// the input stalls while the key's digits pass the collector, one per cycle.
// When the receiver stalls, one further result is held in a skid entry;
// input then stalls only when that entry is also occupied.
// Reset (synchronous, active low) clears the key registers and all per-string
// state, and empties the output buffer.
module keyed_decimal_extractor
    import kde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_key_info w_key;
    logic      w_busy;
    logic      w_full;
    logic      w_accept;
    logic      w_res_valid;
    t_out_item w_res;

    assign o_in_stall = w_busy || w_full;
    assign w_accept = i_in_valid && !o_in_stall;

    kde_key_prep u_key_prep (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_key       (w_key),
        .o_busy      (w_busy)
    );

    kde_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in),
        .i_key       (w_key),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    kde_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_res_valid),
        .i_data      (w_res),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // A held skid entry implies the result register is also occupied.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> o_out_valid)
        else $error("skid entry held with empty result register");

    // No byte is taken while the key digest is being rebuilt.
    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("input not stalled after configuration write");

    // Failure outcomes always carry -1.
    a_fail_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |-> (o_out.number == -64'sd1))
        else $error("failure status without -1");

    // An ok value is never negative.
    a_ok_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status == ST_OK) |-> !o_out.number[63])
        else $error("negative value with ok status");

endmodule

// ----- design/kde_key_prep.sv -----
// Key registers, aligned key for the window compare, and the key digest engine
// that runs the key bytes through the digit collector after each write.
// Depends on kde_pkg.
module kde_key_prep
    import kde_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output t_key_info   o_key,
    output logic        o_busy
);

    logic [5:0]       r_key_len;
    t_key_words       r_key_words;
    logic [31:0][7:0] r_akey;
    logic [31:0][7:0] n_akey;
    logic [31:0]      r_amask;
    logic [31:0]      n_amask;
    logic [5:0]       eff_len;
    logic             r_busy;
    logic [5:0]       r_k;
    t_coll            r_digest;

    assign eff_len = (r_key_len > KEY_MAX) ? KEY_MAX : r_key_len;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= 6'd0;
            r_key_words <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LEN: r_key_len <= i_cfg_data[5:0];
                CFG_KEY_W0:  r_key_words[0] <= i_cfg_data;
                CFG_KEY_W1:  r_key_words[1] <= i_cfg_data;
                CFG_KEY_W2:  r_key_words[2] <= i_cfg_data;
                CFG_KEY_W3:  r_key_words[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Key reversed so that window entry j lines up with key byte len-1-j.
    always_comb begin
        logic [5:0] idx;
        idx = 6'd0;
        for (int j = 0; j < KEY_MAX_BYTES; j++) begin
            idx = eff_len - 6'(j) - 6'd1;
            n_akey[j] = key_byte(r_key_words, idx[4:0]);
            n_amask[j] = (6'(j) < eff_len);
        end
    end

    always_ff @(posedge i_clk) begin
        r_akey <= n_akey;
        r_amask <= n_amask;
    end

    // Digest engine: one key byte per cycle from a clean collector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_k <= 6'd0;
            r_digest <= COLL_CLEAR;
        end else if (i_cfg_we) begin
            r_busy <= 1'b1;
            r_k <= 6'd0;
            r_digest <= COLL_CLEAR;
        end else if (r_busy) begin
            if (r_k < eff_len) begin
                r_digest <= feed_digit(r_digest, key_byte(r_key_words, r_k[4:0]));
                r_k <= r_k + 6'd1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_key = '{akey: r_akey, amask: r_amask, eff_len: eff_len, digest: r_digest};

endmodule

// ----- design/kde_scan.sv -----
// Per-byte scan: byte window, key match, digit collection and result forming.
// Depends on kde_pkg.
module kde_scan
    import kde_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_item  i_item,
    input  t_key_info i_key,
    output logic      o_res_valid,
    output t_out_item o_res
);

    logic [31:0][7:0] r_win;
    logic [31:0][7:0] win_n;
    logic [5:0]       r_seen;
    logic [5:0]       seen_n;
    logic             r_matched;
    logic             matched_n;
    t_coll            r_coll;
    t_coll            coll_n;
    logic             hit;

    // Window after shifting in the new byte; entry 0 is the newest.
    assign win_n = {r_win[30:0], i_item.text_byte};
    assign seen_n = (r_seen < KEY_MAX) ? r_seen + 6'd1 : r_seen;

    always_comb begin
        hit = (seen_n >= i_key.eff_len);
        for (int j = 0; j < KEY_MAX_BYTES; j++) begin
            if (i_key.amask[j] && win_n[j] != i_key.akey[j]) begin
                hit = 1'b0;
            end
        end
    end

    // Collector update. Before a match the collector is clean, so a match on
    // this byte leaves it in the precomputed key digest.
    always_comb begin
        matched_n = r_matched;
        coll_n = r_coll;
        if (r_matched || i_key.eff_len == 6'd0) begin
            matched_n = 1'b1;
            coll_n = feed_digit(r_coll, i_item.text_byte);
        end else if (hit) begin
            matched_n = 1'b1;
            coll_n = i_key.digest;
        end
    end

    // Result on the last byte of a string.
    always_comb begin
        o_res_valid = i_accept && i_item.end_of_text;
        if (!matched_n) begin
            o_res = '{status: ST_NOT_FOUND, number: '1};
        end else if (coll_n.overflow) begin
            o_res = '{status: ST_TOO_MANY, number: '1};
        end else begin
            o_res = '{status: ST_OK, number: {1'b0, coll_n.acc}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
            r_seen <= 6'd0;
            r_matched <= 1'b0;
            r_coll <= COLL_CLEAR;
        end else if (i_accept) begin
            if (i_item.end_of_text) begin
                r_win <= '0;
                r_seen <= 6'd0;
                r_matched <= 1'b0;
                r_coll <= COLL_CLEAR;
            end else begin
                r_win <= win_n;
                r_seen <= seen_n;
                r_matched <= matched_n;
                r_coll <= coll_n;
            end
        end
    end

endmodule

// ----- design/kde_out_buf.sv -----
// Result register with one skid entry, so a single stalled result does not block input.
// Depends on kde_pkg.
module kde_out_buf
    import kde_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_full,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skid_valid;
    t_out_item r_skid;
    logic      pop;

    assign pop = r_out_valid && !i_out_stall;

    // Control; a push never arrives while the skid entry is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || pop) begin
            r_out_valid <= r_skid_valid || i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || pop) begin
            r_out <= r_skid_valid ? r_skid : i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_full = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out = r_out;

endmodule
